// ----- hdl/pnrs_pkg.sv -----
`default_nettype none

package pnrs_pkg;

  // Output image geometry: a power-of-two number of columns.
  localparam int OUT_COL_W   = 8;
  localparam int OUT_CNT_W   = OUT_COL_W + 1;
  localparam int OUT_LINE_W  = 8;
  localparam int OUT_ROWS    = 256;

  // Source frame registers.
  localparam int DIM_W = 12;
  localparam logic [DIM_W-1:0] COLS_RESET = 12'd320;
  localparam logic [DIM_W-1:0] ROWS_RESET = 12'd200;
  localparam logic [DIM_W-1:0] COLS_MIN   = 12'd4;
  localparam logic [DIM_W-1:0] ROWS_MIN   = 12'd1;
  localparam logic [DIM_W-1:0] TALL_LIMIT = 12'd256;

  // Horizontal phase runs in units of 1/(2*OUT_WIDTH) source columns.
  localparam int PHASE_SHIFT = OUT_COL_W + 1;
  localparam int PHASE_W     = 22;
  localparam int PHASE_Q_W   = PHASE_W - PHASE_SHIFT;

  // Vertical accumulator holds i*rows; its upper part is the source row.
  localparam int VACC_W    = 20;
  localparam int ROW_SHIFT = 8;

  // Palette.
  localparam int CH_W      = 8;
  localparam int RGB_W     = 3 * CH_W;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  // Register indexes and request actions.
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_PIXEL   = 1'b1;

  typedef struct packed {
    logic cfg_write;
    logic pal_write;
    logic pix_start;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic more;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/pnrs_ram.sv -----
`default_nettype none

module pnrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pnrs_ctrl.sv -----
`default_nettype none

module pnrs_ctrl import pnrs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire logic    action,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic in_take;
  logic slot_free;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.cfg_write  = cfg_valid && cfg_ready;
    case (state)
      ST_IDLE: begin
        cmd.pal_write = in_take && (action == ACT_PALETTE);
        cmd.pix_start = in_take && (action == ACT_PIXEL);
        if (cmd.pix_start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // Emit one result per cycle while the output slot is free; close the
        // request on its last result, or at once when nothing is emitted.
        cmd.emit   = status.hit && slot_free;
        cmd.finish = !status.hit || (cmd.emit && !status.more);
        if (cmd.finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pnrs_datapath.sv -----
`default_nettype none

module pnrs_datapath import pnrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic              cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data,
  input  wire logic [PAL_AW-1:0] palette_index,
  input  wire logic [CH_W-1:0]   red_in,
  input  wire logic [CH_W-1:0]   green_in,
  input  wire logic [CH_W-1:0]   blue_in,
  input  wire logic [PAL_AW-1:0] pixel_code,
  output logic [CH_W-1:0]        red_out,
  output logic [CH_W-1:0]        green_out,
  output logic [CH_W-1:0]        blue_out,
  output logic [OUT_COL_W-1:0]   out_column,
  output logic [OUT_LINE_W-1:0]  out_line,
  output logic                   last
);

  logic [DIM_W-1:0]     cols;
  logic [DIM_W-1:0]     rows;
  logic [DIM_W-1:0]     src_col;
  logic [DIM_W-1:0]     src_row;
  logic [OUT_CNT_W-1:0] out_row;
  logic [OUT_CNT_W-1:0] out_col;
  logic [PHASE_W-1:0]   phase;
  logic [VACC_W-1:0]    vacc;

  logic [DIM_W-1:0]     cols_next;
  logic [DIM_W-1:0]     rows_next;
  logic [DIM_W-1:0]     src_col_next;
  logic [DIM_W-1:0]     src_row_next;
  logic [OUT_CNT_W-1:0] out_row_next;
  logic [OUT_CNT_W-1:0] out_col_next;
  logic [PHASE_W-1:0]   phase_next;
  logic [VACC_W-1:0]    vacc_next;

  logic [RGB_W-1:0]     rgb;
  logic                 tall;
  logic                 kept;
  logic [OUT_LINE_W-1:0] line;
  logic [PHASE_W-1:0]   phase_step;
  logic [PHASE_W-1:0]   phase_adv;
  logic [OUT_CNT_W-1:0] out_col_adv;
  logic                 col_end;
  logic                 row_end;

  pnrs_ram #(
    .WIDTH(RGB_W),
    .DEPTH(PAL_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (cmd.pal_write),
    .waddr(palette_index),
    .wdata({blue_in, green_in, red_in}),
    .re   (cmd.pix_start),
    .raddr(pixel_code),
    .rdata(rgb)
  );

  // Row selection: every row for short frames, accumulator match otherwise.
  assign tall = (rows > TALL_LIMIT);
  assign kept = !tall ||
                (!out_row[OUT_CNT_W-1] && (src_row == vacc[VACC_W-1:ROW_SHIFT]));
  assign line = tall ? out_row[OUT_LINE_W-1:0] : src_row[OUT_LINE_W-1:0];

  assign phase_step  = PHASE_W'({cols, 1'b0});
  assign phase_adv   = phase + phase_step;
  assign out_col_adv = out_col + OUT_CNT_W'(1);

  assign status.hit  = kept && !out_col[OUT_CNT_W-1] &&
                       (phase[PHASE_W-1:PHASE_SHIFT] <= PHASE_Q_W'(src_col));
  assign status.more = !out_col_adv[OUT_CNT_W-1] &&
                       (phase_adv[PHASE_W-1:PHASE_SHIFT] <= PHASE_Q_W'(src_col));

  assign col_end = ({1'b0, src_col} + (DIM_W+1)'(1)) >= {1'b0, cols};
  assign row_end = ({1'b0, src_row} + (DIM_W+1)'(1)) >= {1'b0, rows};

  always_comb begin
    cols_next    = cols;
    rows_next    = rows;
    src_col_next = src_col;
    src_row_next = src_row;
    out_row_next = out_row;
    out_col_next = out_col;
    phase_next   = phase;
    vacc_next    = vacc;

    if (cmd.emit) begin
      out_col_next = out_col_adv;
      phase_next   = phase_adv;
    end

    if (cmd.finish) begin
      if (col_end) begin
        if (row_end) begin
          src_col_next = '0;
          src_row_next = '0;
          out_row_next = '0;
          vacc_next    = '0;
        end else begin
          src_col_next = '0;
          src_row_next = src_row + DIM_W'(1);
          if (tall && kept) begin
            out_row_next = out_row + OUT_CNT_W'(1);
            vacc_next    = vacc + VACC_W'(rows);
          end
        end
        out_col_next = '0;
        phase_next   = PHASE_W'(cols);
      end else begin
        src_col_next = src_col + DIM_W'(1);
      end
    end

    if (cmd.cfg_write) begin
      if (cfg_index == REG_COLUMNS) begin
        cols_next = (cfg_data < COLS_MIN) ? COLS_MIN : cfg_data;
      end else begin
        rows_next = (cfg_data < ROWS_MIN) ? ROWS_MIN : cfg_data;
      end
      src_col_next = '0;
      src_row_next = '0;
      out_row_next = '0;
      vacc_next    = '0;
      out_col_next = '0;
      phase_next   = PHASE_W'(cols_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols    <= COLS_RESET;
      rows    <= ROWS_RESET;
      src_col <= '0;
      src_row <= '0;
      out_row <= '0;
      out_col <= '0;
      phase   <= PHASE_W'(COLS_RESET);
      vacc    <= '0;
    end else begin
      cols    <= cols_next;
      rows    <= rows_next;
      src_col <= src_col_next;
      src_row <= src_row_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
      phase   <= phase_next;
      vacc    <= vacc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      red_out    <= rgb[CH_W-1:0];
      green_out  <= rgb[2*CH_W-1:CH_W];
      blue_out   <= rgb[3*CH_W-1:2*CH_W];
      out_column <= out_col[OUT_COL_W-1:0];
      out_line   <= line;
      last       <= !status.more;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/palette_nearest_row_scaler_unit.sv -----
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    action, palette_index, red_in, green_in,
//                                             blue_in, pixel_code
// out       output     out_valid / out_stall  red_out, green_out, blue_out, out_column,
//                                             out_line, last
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A palette write request is written into the RAM when it is accepted. A pixel
// request is accepted together with the palette read; the emit loop then produces
// one result per cycle while the output is not stalled, and a request that
// produces none still closes in the run state. The palette RAM has one read port.
// Reset is synchronous and active high; it restores the frame size to 320 x 200
// and clears the frame position. The palette is not cleared.
// A stalled output holds the emit loop; the input stalls until the request's last
// result has been loaded into the output register.
`default_nettype none

module palette_nearest_row_scaler_unit import pnrs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              action,
  input  wire logic [PAL_AW-1:0] palette_index,
  input  wire logic [CH_W-1:0]   red_in,
  input  wire logic [CH_W-1:0]   green_in,
  input  wire logic [CH_W-1:0]   blue_in,
  input  wire logic [PAL_AW-1:0] pixel_code,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CH_W-1:0]        red_out,
  output logic [CH_W-1:0]        green_out,
  output logic [CH_W-1:0]        blue_out,
  output logic [OUT_COL_W-1:0]   out_column,
  output logic [OUT_LINE_W-1:0]  out_line,
  output logic                   last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_data
);

  // The controller sequences each request: palette writes go straight into
  // the RAM, while a pixel request starts a palette read and then walks the
  // output columns that this source column feeds.
  cmd_t    cmd;
  status_t status;

  pnrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the frame registers, the position counters, the
  // horizontal phase and vertical accumulator, the palette and the output
  // register. Any register write restarts the frame.
  pnrs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .palette_index(palette_index),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .pixel_code   (pixel_code),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .out_column   (out_column),
    .out_line     (out_line),
    .last         (last)
  );

endmodule

`default_nettype wire

// ----- sim/palette_nearest_row_scaler_unit_tb.sv -----
`default_nettype none

// Testbench for the palette nearest-neighbor row scaler.
//
// The bench drives palette write requests and indexed pixel requests into the
// block, and it programs the frame size through the register channel. A
// scoreboard object keeps its own copy of the palette, the frame geometry and
// the scan position. For every accepted request it works out the RGB pixels
// the block must produce, with their output column, output line and end
// marker. Every accepted output pixel is checked field by field against the
// oldest pixel still owed.
//
// The run opens with a short directed part and then goes through several
// frame sizes with random requests. Each frame size gets its own mix of
// sender gaps and receiver stalls.
module palette_nearest_row_scaler_unit_tb;
  import pnrs_pkg::*;

  // Most pixels that a single request may produce, and the settling time that
  // is left after the last owed pixel before the frame size is changed.
  localparam int MAX_PIXELS_PER_REQ = 64;
  localparam int SETTLE_CYCLES      = 12;
  localparam int HOLD_CYCLES        = 300;
  localparam int OUT_WIDTH          = 1 << OUT_COL_W;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } color_t;

  typedef struct {
    logic              act;
    logic [PAL_AW-1:0] index;
    color_t            color;
    logic [PAL_AW-1:0] code;
  } request_t;

  typedef struct packed {
    color_t                color;
    logic [OUT_COL_W-1:0]  column;
    logic [OUT_LINE_W-1:0] line;
    logic                  last;
  } pixel_t;

  // The scoreboard follows the block's scan through the source frame. It
  // tracks which source row and column the next pixel request lands on, which
  // output column is due next, and where the horizontal phase and the
  // vertical accumulator stand.
  class pixel_board;
    color_t                palette[PAL_DEPTH];
    logic [DIM_W-1:0]      cols;
    logic [DIM_W-1:0]      rows;
    logic [DIM_W-1:0]      src_row;
    logic [DIM_W-1:0]      src_col;
    logic [OUT_CNT_W-1:0]  out_row;
    logic [OUT_CNT_W-1:0]  out_col;
    logic [PHASE_W-1:0]    phase;
    logic [VACC_W-1:0]     vacc;
    pixel_t                owed[$];
    int                    mismatches;
    int                    checked;
    int                    requests;
    int                    reg_writes;

    function new();
      cols       = COLS_RESET;
      rows       = ROWS_RESET;
      mismatches = 0;
      checked    = 0;
      requests   = 0;
      reg_writes = 0;
      restart();
    endfunction

    // A new frame starts at source row 0. The phase starts half a step into the
    // first output column.
    function void restart();
      src_row = '0;
      src_col = '0;
      out_row = '0;
      out_col = '0;
      vacc    = '0;
      phase   = PHASE_W'(cols);
    endfunction

    function void write_register(logic idx, logic [DIM_W-1:0] data);
      reg_writes++;
      if (idx == REG_COLUMNS) begin
        cols = (data < COLS_MIN) ? COLS_MIN : data;
      end else begin
        rows = (data < ROWS_MIN) ? ROWS_MIN : data;
      end
      restart();
    endfunction

    function void take_request(request_t q);
      bit                    tall;
      bit                    kept;
      logic [OUT_LINE_W-1:0] line;
      color_t                rgb;
      pixel_t                px;
      int                    n;
      requests++;
      if (q.act == ACT_PALETTE) begin
        palette[q.index] = q.color;
        return;
      end
      // A tall frame keeps only the source rows that the accumulator selects.
      // Any other frame keeps every row.
      tall = rows > TALL_LIMIT;
      if (tall) begin
        kept = (out_row < OUT_ROWS) && (src_row == vacc[VACC_W-1:ROW_SHIFT]);
        line = out_row[OUT_LINE_W-1:0];
      end else begin
        kept = 1'b1;
        line = src_row[OUT_LINE_W-1:0];
      end
      n = 0;
      if (kept) begin
        rgb = palette[q.code];
        while (out_col < OUT_WIDTH && (phase >> PHASE_SHIFT) <= src_col) begin
          if (n < MAX_PIXELS_PER_REQ) begin
            px = '{rgb, out_col[OUT_COL_W-1:0], line, 1'b0};
            owed.push_back(px);
            n++;
          end
          out_col++;
          phase += PHASE_W'(2 * cols);
        end
        if (n > 0) owed[$].last = 1'b1;
      end
      // Step to the next source position. At the end of the frame the scan
      // wraps back to the start.
      if (int'(src_col) + 1 >= int'(cols)) begin
        if (int'(src_row) + 1 >= int'(rows)) begin
          restart();
        end else begin
          src_col = '0;
          src_row++;
          if (tall && kept) begin
            out_row++;
            vacc += VACC_W'(rows);
          end
          out_col = '0;
          phase   = PHASE_W'(cols);
        end
      end else begin
        src_col++;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (owed.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel, expected none, got rgb %h col %0d line %0d",
                 $time, got.color, got.column, got.line);
        return;
      end
      want = owed.pop_front();
      checked++;
      compare_field("red", want.color.red, got.color.red);
      compare_field("green", want.color.green, got.color.green);
      compare_field("blue", want.color.blue, got.color.blue);
      compare_field("column", want.column, got.column);
      compare_field("line", want.line, got.line);
      compare_field("last", {7'd0, want.last}, {7'd0, got.last});
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic                  action;
  logic [PAL_AW-1:0]     palette_index;
  logic [CH_W-1:0]       red_in;
  logic [CH_W-1:0]       green_in;
  logic [CH_W-1:0]       blue_in;
  logic [PAL_AW-1:0]     pixel_code;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CH_W-1:0]       red_out;
  logic [CH_W-1:0]       green_out;
  logic [CH_W-1:0]       blue_out;
  logic [OUT_COL_W-1:0]  out_column;
  logic [OUT_LINE_W-1:0] out_line;
  logic                  last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [DIM_W-1:0]      cfg_data;

  pixel_board board = new();

  // These percentages set how often the sender leaves a cycle empty and how
  // often the receiver stalls. The stimulus changes them from phase to phase.
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  // The stimulus bumps hold_req to ask for a long receiver hold-off. The
  // receiver process counts that hold-off down on its own.
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int settings  = 0;

  // Only palette entries that have been written are ever used as pixel codes.
  // Reading an unwritten entry is outside what the block promises.
  bit                palette_known[PAL_DEPTH];
  logic [PAL_AW-1:0] known_codes[$];

  palette_nearest_row_scaler_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .palette_index (palette_index),
    .red_in        (red_in),
    .green_in      (green_in),
    .blue_in       (blue_in),
    .pixel_code    (pixel_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .red_out       (red_out),
    .green_out     (green_out),
    .blue_out      (blue_out),
    .out_column    (out_column),
    .out_line      (out_line),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls at random. A requested hold-off overrides that and
  // keeps the output stalled for a long stretch, so the block fills up and
  // pushes back on its input.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // The monitor samples every handshake at the clock edge that completes it.
  // Register writes and requests go into the scoreboard, and output pixels
  // are checked there.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        board.take_request('{action, palette_index, '{red_in, green_in, blue_in},
                             pixel_code});
      if (out_valid && !out_stall)
        board.check_pixel('{'{red_out, green_out, blue_out}, out_column, out_line, last});
    end
  end

  function automatic request_t palette_request(logic [PAL_AW-1:0] idx, color_t color);
    request_t q;
    q.act   = ACT_PALETTE;
    q.index = idx;
    q.color = color;
    q.code  = PAL_AW'($urandom);
    return q;
  endfunction

  function automatic request_t pixel_request(logic [PAL_AW-1:0] code);
    request_t q;
    q.act   = ACT_PIXEL;
    q.index = PAL_AW'($urandom);
    q.color = RGB_W'($urandom);
    q.code  = code;
    return q;
  endfunction

  // Most random requests are pixels that use a palette entry already written.
  // About one request in seven rewrites a random entry.
  function automatic request_t random_request();
    request_t q;
    if (known_codes.size() == 0 || $urandom_range(99) < 15) begin
      q = palette_request(PAL_AW'($urandom), RGB_W'($urandom));
    end else begin
      q = pixel_request(known_codes[$urandom_range(known_codes.size() - 1)]);
    end
    return q;
  endfunction

  // Offer one request and hold it steady until the block takes it. Valid is
  // left high afterwards, so back-to-back requests need no idle cycle.
  task automatic send(input request_t q);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    if (q.act == ACT_PALETTE && !palette_known[q.index]) begin
      palette_known[q.index] = 1'b1;
      known_codes.push_back(q.index);
    end
    in_valid      <= 1'b1;
    action        <= q.act;
    palette_index <= q.index;
    red_in        <= q.color.red;
    green_in      <= q.color.green;
    blue_in       <= q.color.blue;
    pixel_code    <= q.code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering requests and wait until every owed pixel has arrived. A
  // request that produced no pixel may still be inside the block, so the task
  // waits out a settling time before the caller goes on.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.owed.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
    drain();
    write_register(REG_COLUMNS, cols);
    write_register(REG_ROWS, rows);
    settings++;
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                           input int count, input int gap_pct, input int stall_pct,
                           input bit hold);
    set_frame(cols, rows);
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    if (hold) hold_req++;
    repeat (count) send(random_request());
  endtask

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    action        <= ACT_PIXEL;
    palette_index <= '0;
    red_in        <= '0;
    green_in      <= '0;
    blue_in       <= '0;
    pixel_code    <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_COLUMNS;
    cfg_data      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, first at the reset frame size of 320 x 200. The palette
    // entries at both ends of the index range get written first. At this width
    // source columns 0 and 1 each feed one output column, column 2 is skipped,
    // and column 3 feeds one again. A palette write in the middle of the row
    // must not move the scan position.
    send(palette_request(8'h00, 24'h000000));
    send(palette_request(8'hff, 24'hffffff));
    send(palette_request(8'h5a, 24'ha55ac3));
    send(pixel_request(8'h00));
    send(pixel_request(8'hff));
    send(pixel_request(8'h5a));
    send(palette_request(8'h00, 24'h3cc381));
    send(pixel_request(8'h00));

    // Zero writes clamp to the narrowest width and a single row. Every pixel
    // then fans out to 64 output columns, and the frame wraps every four
    // pixels.
    set_frame('0, '0);
    send(pixel_request(8'hff));
    send(pixel_request(8'h00));
    send(pixel_request(8'h5a));
    send(pixel_request(8'hff));
    send(pixel_request(8'h00));

    // At the widest and tallest frame the first source columns feed nothing.
    set_frame(12'hfff, 12'hfff);
    send(pixel_request(8'h5a));
    send(pixel_request(8'hff));

    // A tall frame with twice the output height keeps every other row. Row 0
    // is emitted in full and row 1 is dropped.
    set_frame(12'd4, 12'd512);
    repeat (8) send(pixel_request(known_codes[$urandom_range(known_codes.size() - 1)]));

    // Random part. The first phase holds the receiver off while the sender
    // keeps pushing, so the block fills up and stalls its input.
    run_phase(12'd4, 12'd4095, 90, 0, 0, 1'b1);
    run_phase(12'd4095, 12'd1, 50, 81, 0, 1'b0);
    run_phase(12'd300, 12'd257, 60, 0, 81, 1'b0);
    run_phase(12'd5, 12'd3, 60, 19, 19, 1'b0);
    run_phase(12'd256, 12'd256, 50, 0, 0, 1'b0);
    run_phase(DIM_W'($urandom_range(4, 24)), DIM_W'($urandom_range(1, 8)), 40, 81, 0,
              1'b0);
    run_phase(DIM_W'($urandom_range(4, 12)), DIM_W'($urandom_range(257, 600)), 40, 0, 81,
              1'b0);
    drain();

    $display("Ran %0d requests over %0d frame sizes with %0d register writes;",
             board.requests, settings, board.reg_writes);
    $display("compared %0d output pixels, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // This watchdog is far beyond the slowest legal run. It catches a block that
  // hangs on a handshake.
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/pnrs_pkg.sv
hdl/pnrs_ram.sv
hdl/pnrs_ctrl.sv
hdl/pnrs_datapath.sv
hdl/palette_nearest_row_scaler_unit.sv
sim/palette_nearest_row_scaler_unit_tb.sv
